// ----- src/pausable_frame_clock_rate_meter_assert.svh -----
`ifndef PAUSABLE_FRAME_CLOCK_RATE_METER_ASSERT_SVH
`define PAUSABLE_FRAME_CLOCK_RATE_METER_ASSERT_SVH

// same-cycle implication
`define PFCRM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFCRM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pfcrm_pkg.sv -----
`timescale 1ns / 1ps

package pfcrm_pkg;

    localparam int WINDOW_DEPTH_DEF = 256;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CMD_W   = 3;
    localparam int FRAME_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] MAX_STEP_RST = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd1000;

    localparam logic [CMD_W-1:0] CMD_FRAME    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAUSE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTINUE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;

    typedef struct packed {
        logic drop;
        logic push;
    } ring_ctrl_t;

    typedef struct packed {
        logic expired;
    } ring_stat_t;

endpackage

// ----- src/pausable_frame_clock_rate_meter.sv -----
`timescale 1ns / 1ps
// Flow: an input goes through ACT, RAW, CLAMP, POP and DONE; DONE loads the result
//   once the output is free, and only then is a new frame accepted in IDLE. The window scan
//   in POP pops one ring entry per cycle through the single read port of the stamp memory.
// Reset: synchronous, active low; clock state, configuration, the state machine and output valid
//   take their reset values, the ring starts empty and its memory is not cleared (no clearing pass).

`include "pausable_frame_clock_rate_meter_assert.svh"

module pausable_frame_clock_rate_meter
    import pfcrm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [TIME_W-1:0]     s_real_time_ms,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [TIME_W-1:0]     m_game_time_ms,
    output logic [TIME_W-1:0]     m_game_delta_ms,
    output logic [TIME_W-1:0]     m_real_delta_ms,
    output logic                  m_paused,
    output logic [FRAME_W-1:0]    m_frames_in_window
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACT   = 3'd1;
    localparam logic [2:0] S_RAW   = 3'd2;
    localparam logic [2:0] S_CLAMP = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [CFG_W-1:0] max_step_reg, max_step_next;
    logic [CFG_W-1:0] window_reg, window_next;

    logic              is_paused_reg, is_paused_next;
    logic [TIME_W-1:0] time_base_reg, time_base_next;
    logic [TIME_W-1:0] pause_start_reg, pause_start_next;
    logic [TIME_W-1:0] last_game_reg, last_game_next;
    logic [TIME_W-1:0] last_real_reg, last_real_next;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] oldest_ok_reg, oldest_ok_next;
    logic              early_reg, early_next;
    logic [TIME_W-1:0] real_delta_reg, real_delta_next;
    logic [TIME_W-1:0] raw_reg, raw_next;
    logic [TIME_W-1:0] limit_reg, limit_next;
    logic [TIME_W-1:0] game_delta_reg, game_delta_next;

    logic               m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]  m_game_reg, m_game_next;
    logic [TIME_W-1:0]  m_game_delta_reg, m_game_delta_next;
    logic [TIME_W-1:0]  m_real_delta_reg, m_real_delta_next;
    logic               m_paused_reg, m_paused_next;
    logic [FRAME_W-1:0] m_frames_reg, m_frames_next;

    logic       flip;
    logic       over;
    logic       out_free;
    ring_ctrl_t ring_ctrl;
    ring_stat_t ring_stat;
    logic [FRAME_W-1:0] frames;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign over      = raw_reg > limit_reg;

    always_comb begin
        max_step_next = max_step_reg;
        window_next   = window_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_STEP: max_step_next = cfg_data;
                REG_WINDOW:   window_next   = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cmd_reg)
            CMD_TOGGLE:   flip = 1'b1;
            CMD_PAUSE:    flip = !is_paused_reg;
            CMD_CONTINUE: flip = is_paused_reg;
            default:      flip = 1'b0;
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        is_paused_next    = is_paused_reg;
        time_base_next    = time_base_reg;
        pause_start_next  = pause_start_reg;
        last_game_next    = last_game_reg;
        last_real_next    = last_real_reg;
        cmd_next          = cmd_reg;
        now_next          = now_reg;
        oldest_ok_next    = oldest_ok_reg;
        early_next        = early_reg;
        real_delta_next   = real_delta_reg;
        raw_next          = raw_reg;
        limit_next        = limit_reg;
        game_delta_next   = game_delta_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_game_next       = m_game_reg;
        m_game_delta_next = m_game_delta_reg;
        m_real_delta_next = m_real_delta_reg;
        m_paused_next     = m_paused_reg;
        m_frames_next     = m_frames_reg;
        ring_ctrl         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    now_next   = s_real_time_ms;
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                if (flip) begin
                    if (is_paused_reg) begin
                        is_paused_next = 1'b0;
                        time_base_next = last_real_reg - pause_start_reg;
                    end else begin
                        is_paused_next   = 1'b1;
                        pause_start_next = last_game_reg;
                    end
                end else if (cmd_reg == CMD_RESTART) begin
                    time_base_next = now_reg;
                    last_game_next = '0;
                end
                oldest_ok_next  = now_reg - TIME_W'(window_reg);
                early_next      = now_reg < TIME_W'(window_reg);
                real_delta_next = now_reg - last_real_reg;
                last_real_next  = now_reg;
                state_next      = S_RAW;
            end
            S_RAW: begin
                raw_next   = now_reg - time_base_reg;
                limit_next = last_game_reg + TIME_W'(max_step_reg);
                state_next = S_CLAMP;
            end
            S_CLAMP: begin
                if (is_paused_reg) begin
                    game_delta_next = '0;
                end else if (over) begin
                    last_game_next  = limit_reg;
                    time_base_next  = now_reg - limit_reg;
                    game_delta_next = TIME_W'(max_step_reg);
                end else begin
                    last_game_next  = raw_reg;
                    game_delta_next = raw_reg - last_game_reg;
                end
                state_next = S_POP;
            end
            S_POP: begin
                if (ring_stat.expired) begin
                    ring_ctrl.drop = 1'b1;
                end else begin
                    ring_ctrl.push = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_game_next       = last_game_reg;
                    m_game_delta_next = game_delta_reg;
                    m_real_delta_next = real_delta_reg;
                    m_paused_next     = is_paused_reg;
                    m_frames_next     = frames;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    pfcrm_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ring_ctrl),
        .oldest_ok (oldest_ok_reg),
        .early     (early_reg),
        .wr_stamp  (now_reg),
        .stat      (ring_stat),
        .frames    (frames)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            max_step_reg    <= MAX_STEP_RST;
            window_reg      <= WINDOW_RST;
            is_paused_reg   <= 1'b0;
            time_base_reg   <= '0;
            pause_start_reg <= '0;
            last_game_reg   <= '0;
            last_real_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            max_step_reg    <= max_step_next;
            window_reg      <= window_next;
            is_paused_reg   <= is_paused_next;
            time_base_reg   <= time_base_next;
            pause_start_reg <= pause_start_next;
            last_game_reg   <= last_game_next;
            last_real_reg   <= last_real_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        now_reg          <= now_next;
        oldest_ok_reg    <= oldest_ok_next;
        early_reg        <= early_next;
        real_delta_reg   <= real_delta_next;
        raw_reg          <= raw_next;
        limit_reg        <= limit_next;
        game_delta_reg   <= game_delta_next;
        m_game_reg       <= m_game_next;
        m_game_delta_reg <= m_game_delta_next;
        m_real_delta_reg <= m_real_delta_next;
        m_paused_reg     <= m_paused_next;
        m_frames_reg     <= m_frames_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_game_time_ms     = m_game_reg;
    assign m_game_delta_ms    = m_game_delta_reg;
    assign m_real_delta_ms    = m_real_delta_reg;
    assign m_paused           = m_paused_reg;
    assign m_frames_in_window = m_frames_reg;

    `PFCRM_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_valid && s_ready,
        state_reg == S_ACT, "input transfer did not start processing")
    `PFCRM_ASSERT_NXT(a_done_loads, aclk, aresetn, state_reg == S_DONE && out_free,
        m_valid_reg && state_reg == S_IDLE, "finished frame not loaded")
    `PFCRM_ASSERT_NXT(a_done_stalls, aclk, aresetn,
        state_reg == S_DONE && m_valid_reg && !m_ready,
        state_reg == S_DONE, "result overwritten while stalled")

endmodule

// ----- src/pfcrm_ring.sv -----
`timescale 1ns / 1ps

`include "pausable_frame_clock_rate_meter_assert.svh"

module pfcrm_ring
    import pfcrm_pkg::*;
#(
    parameter int DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ring_ctrl_t          ctrl,
    input  logic [TIME_W-1:0]   oldest_ok,
    input  logic                early,
    input  logic [TIME_W-1:0]   wr_stamp,
    output ring_stat_t          stat,
    output logic [FRAME_W-1:0]  frames
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [AW-1:0]   head_inc;
    logic [AW:0]     wr_sum;
    logic [AW-1:0]   wr_addr;
    logic            full;
    logic [CW+8:0]   cnt_ext;

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wr_sum   = (AW+1)'(head_reg) + (AW+1)'(cnt_reg);
    assign wr_addr  = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH))
                                                 : wr_sum[AW-1:0];
    assign full     = (cnt_reg == CW'(DEPTH));

    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (ctrl.drop) begin
            head_next = head_inc;
            cnt_next  = cnt_reg - 1'b1;
        end else if (ctrl.push) begin
            if (full) begin
                head_next = head_inc;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // read port follows the next head, so rd_data_reg is the oldest stamp
    assign stat.expired = (cnt_reg != '0) && !early && (rd_data_reg <= oldest_ok);

    assign cnt_ext = (CW+9)'(cnt_reg);
    assign frames  = cnt_ext[FRAME_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_addr] <= wr_stamp;
        end
        rd_data_reg <= mem[head_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    `PFCRM_ASSERT_IMP(a_drop_nonempty, aclk, aresetn, ctrl.drop, cnt_reg != '0,
        "ring drop while empty")
    `PFCRM_ASSERT_NXT(a_full_push_keeps, aclk, aresetn, ctrl.push && full,
        cnt_reg == CW'(DEPTH), "push into full ring changed count")
    `PFCRM_ASSERT_NXT(a_push_grows, aclk, aresetn, ctrl.push && !full,
        cnt_reg == $past(cnt_reg) + 1'b1, "push did not grow count")

endmodule
